// File: src/whs_pkg.sv
`timescale 1ns / 1ps

package whs_pkg;

    localparam int unsigned PC_W = 4;

    localparam logic [31:0] MIX_MUL_A = 32'hd168aaad;
    localparam logic [31:0] MIX_MUL_B = 32'haf723597;
    localparam logic [31:0] BYTE_MUL  = 32'd101;
    localparam int unsigned MIX_SHIFT = 15;

    // datapath operations
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_NOP,
        OP_ADD_WORD,
        OP_ADD_BH,
        OP_BH_STEP,
        OP_XS,
        OP_XS_END,
        OP_MUL_A,
        OP_MUL_B,
        OP_EMIT
    } whs_op_t;

    // jump conditions; taken -> target, else pc + 1
    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_IN_IDLE,
        C_WORD_PATH,
        C_BYTES_DONE,
        C_MIX_AGAIN,
        C_OUT_BLOCKED
    } whs_cond_t;

    typedef struct packed {
        whs_op_t          op;
        whs_cond_t        cond;
        logic [PC_W-1:0]  target;
    } whs_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic word_path;
        logic bytes_done;
        logic mix_again;
        logic out_blocked;
    } whs_status_t;

    // microprogram
    function automatic whs_ctrl_t whs_rom(input logic [PC_W-1:0] pc);
        whs_ctrl_t w;
        w = '{op: OP_IDLE, cond: C_IN_IDLE, target: 4'd0};
        unique case (pc)
            4'd0:  w = '{op: OP_IDLE,     cond: C_IN_IDLE,     target: 4'd0};
            4'd1:  w = '{op: OP_NOP,      cond: C_WORD_PATH,   target: 4'd5};
            4'd2:  w = '{op: OP_NOP,      cond: C_BYTES_DONE,  target: 4'd4};
            4'd3:  w = '{op: OP_BH_STEP,  cond: C_ALWAYS,      target: 4'd2};
            4'd4:  w = '{op: OP_ADD_BH,   cond: C_ALWAYS,      target: 4'd6};
            4'd5:  w = '{op: OP_ADD_WORD, cond: C_NONE,        target: 4'd0};
            4'd6:  w = '{op: OP_XS,       cond: C_NONE,        target: 4'd0};
            4'd7:  w = '{op: OP_MUL_A,    cond: C_NONE,        target: 4'd0};
            4'd8:  w = '{op: OP_XS,       cond: C_NONE,        target: 4'd0};
            4'd9:  w = '{op: OP_MUL_B,    cond: C_NONE,        target: 4'd0};
            4'd10: w = '{op: OP_XS_END,   cond: C_MIX_AGAIN,   target: 4'd6};
            4'd11: w = '{op: OP_NOP,      cond: C_OUT_BLOCKED, target: 4'd11};
            4'd12: w = '{op: OP_EMIT,     cond: C_ALWAYS,      target: 4'd0};
            default: w = '{op: OP_IDLE,   cond: C_ALWAYS,      target: 4'd0};
        endcase
        return w;
    endfunction

endpackage

// File: src/word_string_hash.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                          Contents
// s_axis    in   tvalid tready tdata[39:0] tlast  string word, byte count, last mark
// m_axis    out  tvalid tready tdata[31:0]        hash of a completed string
//
// One word at a time: a new word is taken only at the idle step, once the
// previous word has run through the microprogram. The microprogram runs on one
// shared 32-bit multiplier, one datapath step per program step; each byte of
// the tail hash takes a byte test step and a multiply step. Reset puts the
// running hash at zero, the string start flag at one and the sequencer at its
// idle step. A stalled result holds the sequencer at its wait step near the
// end of every word; the output register lets the first word of the next
// string be taken while an earlier hash waits.
module word_string_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] byte_count, [39:35] zero
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] hash_value
);

    whs_pkg::whs_ctrl_t   ctrl;
    whs_pkg::whs_status_t status;

    // control state
    logic        start_reg, start_next;
    logic [31:0] acc_reg, acc_next;       // running hash / mix value
    logic        out_valid_reg, out_valid_next;
    logic        mix2_reg, mix2_next;     // full last word: second mix pending
    logic [2:0]  idx_reg, idx_next;       // tail byte index
    logic [2:0]  cnt_reg, cnt_next;       // saturated byte count

    // payload
    logic [31:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic        bytes_reg, bytes_next;   // tail goes through the byte hash
    logic [31:0] bh_reg, bh_next;
    logic [31:0] out_reg, out_next;

    logic        in_acc;
    logic [2:0]  cnt_sat;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] product;
    logic [7:0]  byte_sel;

    whs_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign s_axis_tready = (ctrl.op == whs_pkg::OP_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign cnt_sat  = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
    assign byte_sel = word_reg[{idx_reg[1:0], 3'b000} +: 8];

    assign status = '{
        in_valid:    s_axis_tvalid,
        word_path:   !bytes_reg,
        bytes_done:  (idx_reg == cnt_reg),
        mix_again:   mix2_reg,
        out_blocked: out_valid_reg && !m_axis_tready
    };

    // the one multiplier, shared by the mix and the byte hash
    always_comb
    begin
        mul_a = acc_reg;
        mul_b = whs_pkg::MIX_MUL_A;
        unique case (ctrl.op)
            whs_pkg::OP_MUL_B:   mul_b = whs_pkg::MIX_MUL_B;
            whs_pkg::OP_BH_STEP:
            begin
                mul_a = bh_reg;
                mul_b = whs_pkg::BYTE_MUL;
            end
            default:             mul_b = whs_pkg::MIX_MUL_A;
        endcase
        product = mul_a * mul_b;
    end

    always_comb
    begin
        start_next     = start_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        mix2_next      = mix2_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        bytes_next     = bytes_reg;
        bh_next        = bh_reg;
        out_next       = out_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctrl.op)
            whs_pkg::OP_IDLE:
            begin
                if (in_acc)
                begin
                    word_next  = s_axis_tdata[31:0];
                    cnt_next   = cnt_sat;
                    last_next  = s_axis_tlast;
                    bytes_next = s_axis_tlast && (start_reg || (cnt_sat != 3'd4));
                    mix2_next  = s_axis_tlast && !start_reg && (cnt_sat == 3'd4);
                    idx_next   = '0;
                    bh_next    = '0;
                end
            end
            whs_pkg::OP_ADD_WORD: acc_next = acc_reg + word_reg;
            whs_pkg::OP_ADD_BH:   acc_next = acc_reg + bh_reg;
            whs_pkg::OP_BH_STEP:
            begin
                bh_next  = product + {{24{byte_sel[7]}}, byte_sel};
                idx_next = idx_reg + 3'd1;
            end
            whs_pkg::OP_XS:       acc_next = acc_reg ^ (acc_reg >> whs_pkg::MIX_SHIFT);
            whs_pkg::OP_XS_END:
            begin
                acc_next  = acc_reg ^ (acc_reg >> whs_pkg::MIX_SHIFT);
                mix2_next = 1'b0;
            end
            whs_pkg::OP_MUL_A,
            whs_pkg::OP_MUL_B:    acc_next = product;
            whs_pkg::OP_EMIT:
            begin
                if (last_reg)
                begin
                    out_next       = acc_reg;
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                    start_next     = 1'b1;
                end
                else
                begin
                    start_next = 1'b0;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= 1'b1;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            mix2_reg      <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            start_reg     <= start_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            mix2_reg      <= mix2_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        last_reg  <= last_next;
        bytes_reg <= bytes_next;
        bh_reg    <= bh_next;
        out_reg   <= out_next;
    end

    // the result slot is free whenever a hash is written into it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == whs_pkg::OP_EMIT && last_reg) |-> !out_valid_reg)
        else $error("result written over a pending hash");

    // the tail byte loop never runs past the byte count
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= cnt_reg)
        else $error("byte index past byte count");

    // a finished string leaves a clean running hash
    a_string_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == whs_pkg::OP_EMIT && last_reg) |=> (acc_reg == '0) && start_reg)
        else $error("running hash not cleared after a string");

    // no second mix is left pending once back at idle
    a_mix2_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !mix2_reg)
        else $error("second mix pending at idle");

endmodule

// File: src/whs_seq.sv
`timescale 1ns / 1ps

// Step counter and microprogram fetch.
module whs_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  whs_pkg::whs_status_t status,
    output whs_pkg::whs_ctrl_t   ctrl
);

    logic [whs_pkg::PC_W-1:0] pc_reg;
    logic [whs_pkg::PC_W-1:0] pc_next;
    logic                     taken;

    assign ctrl = whs_pkg::whs_rom(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            whs_pkg::C_NONE:        taken = 1'b0;
            whs_pkg::C_ALWAYS:      taken = 1'b1;
            whs_pkg::C_IN_IDLE:     taken = !status.in_valid;
            whs_pkg::C_WORD_PATH:   taken = status.word_path;
            whs_pkg::C_BYTES_DONE:  taken = status.bytes_done;
            whs_pkg::C_MIX_AGAIN:   taken = status.mix_again;
            whs_pkg::C_OUT_BLOCKED: taken = status.out_blocked;
            default:                taken = 1'b1;
        endcase
        pc_next = taken ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

// Checks word_string_hash against a behavioral predictor of the string hash.
// Strings go in as 32-bit words with a byte count and a last mark; each last
// word yields one hash, which is compared in order against the predicted one.
module testbench;

    localparam int unsigned    CLK_HALF     = 4;
    localparam int unsigned    RUN_LIMIT    = 200000;   // cycles before giving up
    localparam int unsigned    TARGET_WORDS = 470;      // directed + random words
    localparam int unsigned    QUIET_TAIL   = 60;       // last words sent without idling
    localparam int unsigned    HOLD_AT      = 150;      // words accepted before the long hold
    localparam int unsigned    HOLD_CYCLES  = 300;
    localparam int unsigned    DRAIN_AT     = 300;      // second sender pause point
    localparam int unsigned    SETTLE       = 40;       // settling wait before the final check

    // hash constants
    localparam logic [31:0]    MUL_FIRST    = 32'hd168aaad;
    localparam logic [31:0]    MUL_SECOND   = 32'haf723597;
    localparam logic [31:0]    CHAR_MUL     = 32'd101;
    localparam int unsigned    XS_SHIFT     = 15;
    localparam logic [2:0]     FULL_WORD    = 3'd4;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
        int unsigned gap_after;     // sender idle cycles after this word
        logic        drain;         // wait for every hash before offering
    } word_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // [31:0] data_word, [34:32] byte_count, [39:35] zero
    logic        s_axis_tlast = 1'b0;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] hash_value

    word_item_t  word_q[$];             // words not yet offered
    logic [31:0] pending_hashes[$];     // predicted hashes not yet seen
    logic [31:0] string_hash = '0;      // running hash of the open string
    logic        string_fresh = 1'b1;   // no word of the open string taken yet

    int unsigned total_words = 0;
    int unsigned accepted_words = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic        send_idles = 1'b0;     // idling style of the string being built

    word_string_hash dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // xorshift-multiply finalizer
    function automatic logic [31:0] scramble(input logic [31:0] v);
        v = v ^ (v >> XS_SHIFT);
        v = v * MUL_FIRST;
        v = v ^ (v >> XS_SHIFT);
        v = v * MUL_SECOND;
        v = v ^ (v >> XS_SHIFT);
        return v;
    endfunction

    // times-101 hash over the low n bytes, each taken as a signed char
    function automatic logic [31:0] tail_hash(input logic [31:0] data, input logic [2:0] n);
        logic [31:0] h;
        logic [7:0]  b;
        h = '0;
        for (int i = 0; i < n; i++) begin
            b = data[8*i +: 8];
            h = h * CHAR_MUL + {{24{b[7]}}, b};
        end
        return h;
    endfunction

    // advance the string state by one accepted word; a last word yields a hash
    task automatic absorb_word(input logic [31:0] data, input logic [2:0] count,
                               input logic last);
        logic [2:0]  n;
        logic [31:0] h;
        if (!last) begin
            string_hash  = scramble(string_hash + data);
            string_fresh = 1'b0;
        end else begin
            n = (count > FULL_WORD) ? FULL_WORD : count;
            if (string_fresh)
                h = scramble(tail_hash(data, n));
            else if (n == FULL_WORD)
                h = scramble(scramble(string_hash + data));
            else
                h = scramble(string_hash + tail_hash(data, n));
            pending_hashes.push_back(h);
            string_hash  = '0;
            string_fresh = 1'b1;
        end
    endtask

    task automatic queue_word(input logic [31:0] data, input logic [2:0] count,
                              input logic last, input logic drain);
        word_item_t w;
        w.data      = data;
        w.count     = count;
        w.last      = last;
        w.drain     = drain;
        w.gap_after = (send_idles && $urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
        word_q.push_back(w);
        total_words++;
    endtask

    // stimulus and end of run
    initial begin
        int unsigned n_words;
        int unsigned r;
        logic [2:0]  cnt;
        logic [31:0] data;
        logic        drain;
        logic        late_drain_done;

        // lone last words: zero count, every legal count, counts that saturate
        send_idles = 1'b1;
        queue_word(32'hffffffff, 3'd0, 1'b1, 1'b0);
        queue_word(32'h00000080, 3'd1, 1'b1, 1'b0);
        queue_word(32'h00007f80, 3'd2, 1'b1, 1'b0);
        queue_word(32'hffffffff, 3'd3, 1'b1, 1'b0);
        queue_word(32'h80ff7f00, 3'd4, 1'b1, 1'b0);
        queue_word(32'h12345678, 3'd5, 1'b1, 1'b0);
        queue_word(32'hffffffff, 3'd7, 1'b1, 1'b0);
        // full last word after a word; the earlier word's count is ignored
        queue_word(32'hffffffff, 3'd6, 1'b0, 1'b0);
        queue_word(32'h00000000, 3'd4, 1'b1, 1'b0);
        // zero-count last word after a word
        queue_word(32'h00000000, 3'd0, 1'b0, 1'b0);
        queue_word(32'hffffffff, 3'd0, 1'b1, 1'b0);
        // partial tail with sign-extended bytes
        queue_word(32'h80808080, 3'd1, 1'b0, 1'b0);
        queue_word(32'h7f7f7f7f, 3'd3, 1'b0, 1'b0);
        queue_word(32'h0000ff80, 3'd3, 1'b1, 1'b0);
        // saturating count after a word takes the full-word path; then saturating counts on non-last words
        queue_word(32'hdeadbeef, 3'd2, 1'b0, 1'b0);
        queue_word(32'hcafef00d, 3'd6, 1'b1, 1'b0);
        queue_word(32'h01020304, 3'd7, 1'b0, 1'b0);
        queue_word(32'h000000ff, 3'd1, 1'b1, 1'b0);
        queue_word(32'h55aa55aa, 3'd5, 1'b0, 1'b0);
        queue_word(32'haa55aa55, 3'd2, 1'b1, 1'b0);

        // random strings; the first one waits for the directed hashes to drain
        drain = 1'b1;
        late_drain_done = 1'b0;
        while (total_words < TARGET_WORDS) begin
            send_idles = ($urandom_range(0, 2) != 0);
            n_words = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
            if (!late_drain_done && total_words >= DRAIN_AT) begin
                drain = 1'b1;
                late_drain_done = 1'b1;
            end
            for (int i = 1; i <= n_words; i++) begin
                data = $urandom();
                if ($urandom_range(0, 5) == 0) begin
                    // bytes near the sign boundary
                    for (int k = 0; k < 4; k++) begin
                        case ($urandom_range(0, 3))
                            0:       data[8*k +: 8] = 8'h00;
                            1:       data[8*k +: 8] = 8'h7f;
                            2:       data[8*k +: 8] = 8'h80;
                            default: data[8*k +: 8] = 8'hff;
                        endcase
                    end
                end
                if (i < n_words) begin
                    cnt = 3'($urandom_range(0, 7));
                end else begin
                    r = $urandom_range(0, 15);
                    if (r < 12)
                        cnt = 3'(1 + r % 4);
                    else if (r == 12)
                        cnt = 3'd0;
                    else
                        cnt = 3'(r - 8);
                end
                queue_word(data, cnt, i == n_words, drain);
                drain = 1'b0;
            end
        end
        // no sender idling at the end of the run
        for (int i = word_q.size() - QUIET_TAIL; i < word_q.size(); i++)
            word_q[i].gap_after = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_words == total_words);
        wait (pending_hashes.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (pending_hashes.size() != 0) begin
            $error("hash_value: %0d expected hashes never arrived", pending_hashes.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // driver: offers one word at a time from the queue
    always @(posedge clk or negedge rst_n) begin
        word_item_t w;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            send_gap      <= 0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            // slot free: nothing offered, or the word on the bus goes at this edge
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (word_q.size() != 0 &&
                         !(word_q[0].drain && (s_axis_tvalid || pending_hashes.size() != 0))) begin
                w = word_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'b0, w.count, w.data};
                s_axis_tlast  <= w.last;
                send_gap      <= w.gap_after;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // predictor: runs on every accepted word
    always @(posedge clk) begin
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            absorb_word(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
            accepted_words++;
        end
    end

    // receiver: random stall bursts, one long hold, none near the end
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end else if (!hold_done && accepted_words >= HOLD_AT) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (word_q.size() > QUIET_TAIL && (cycle_count / 256) % 3 != 0 &&
                     $urandom_range(0, 3) == 0) begin
            stall_left    <= $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: each hash against the oldest prediction
    always @(posedge clk) begin
        logic [31:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_hashes.size() == 0) begin
                $error("hash_value: no hash expected, got %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_hashes.pop_front();
                if (m_axis_tdata !== want) begin
                    $error("hash_value: expected %h, got %h", want, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
